### sv/utf8_validate_trim_bounds_unit_assert.svh
// Assertion macros shared by the validator RTL; they compile to nothing in synthesis.
`ifndef UTF8_VALIDATE_TRIM_BOUNDS_UNIT_ASSERT_SVH
`define UTF8_VALIDATE_TRIM_BOUNDS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define U8VTB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8vtb assertion failed");
`define U8VTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8vtb assertion failed");
`else
`define U8VTB_ASSERT_IMPLIES(label, ante, cons)
`define U8VTB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/u8vtb_pkg.sv
// Types, constants and the whitespace classifier for the UTF-8 trim validator.
package u8vtb_pkg;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_class_t;

    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;
    localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

    typedef struct packed {
        logic [15:0] byte_offset;
        logic [15:0] first_position;
        logic [15:0] last_end;
        logic        seen_nonspace;
        logic [1:0]  bytes_pending;
        logic [20:0] code_accumulator;
        seq_class_t  sequence_class;
        logic [15:0] sequence_start;
        logic        error_seen;
    } scan_state_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] trim_start;
        logic [15:0] trim_length;
    } result_t;

    function automatic logic is_space(input logic [20:0] cp);
        return (cp >= 21'd9 && cp <= 21'd13) || cp == 21'd32 || cp == 21'd160 ||
            cp == 21'd5760 || (cp >= 21'd8192 && cp <= 21'd8202) ||
            cp == 21'd8232 || cp == 21'd8233 || cp == 21'd8239 ||
            cp == 21'd8287 || cp == 21'd12288 || cp == 21'd65279;
    endfunction

endpackage

### sv/u8vtb_step.sv
// Next-state and result logic for one registered byte item.
module u8vtb_step #(
    parameter logic [16:0] LEN_CAP = 17'h10000
) (
    input  u8vtb_pkg::scan_state_t cur,
    input  logic [7:0]             data_byte,
    input  logic                   is_last,
    input  logic                   is_empty,
    output u8vtb_pkg::scan_state_t nxt,
    output logic                   emit,
    output u8vtb_pkg::result_t     res
);
    import u8vtb_pkg::*;

    logic [15:0] pos;
    logic [15:0] pos_inc;
    logic        err;
    logic        fin;
    logic [20:0] fin_cp;
    logic [15:0] fin_start;
    logic [20:0] acc_shift;
    logic [20:0] cp_min;
    logic        ok;

    assign pos       = cur.byte_offset;
    assign pos_inc   = pos + 16'd1;
    assign acc_shift = {cur.code_accumulator[14:0], data_byte[5:0]};

    always_comb
    begin
        unique case (cur.sequence_class)
            SEQ_NONE:  cp_min = MIN_TWO;
            SEQ_TWO:   cp_min = MIN_TWO;
            SEQ_THREE: cp_min = MIN_THREE;
            SEQ_FOUR:  cp_min = MIN_FOUR;
        endcase
    end

    always_comb
    begin
        nxt       = cur;
        err       = cur.error_seen;
        fin       = 1'b0;
        fin_cp    = '0;
        fin_start = '0;
        emit      = 1'b0;
        res       = '0;
        ok        = 1'b0;
        if (is_empty)
        begin
            nxt           = '0;
            emit          = 1'b1;
            res.valid_res = 1'b1;
        end
        else
        begin
            if (pos == OFFSET_TOP || {1'b0, pos} >= LEN_CAP)
            begin
                err = 1'b1;
            end
            if (pos != OFFSET_TOP)
            begin
                nxt.byte_offset = pos_inc;
            end
            if (!err)
            begin
                if (cur.bytes_pending == 2'd0)
                begin
                    priority if (data_byte >= 8'd1 && data_byte <= 8'd127)
                    begin
                        fin       = 1'b1;
                        fin_cp    = {13'd0, data_byte};
                        fin_start = pos;
                    end
                    else if (data_byte >= 8'd194 && data_byte <= 8'd223)
                    begin
                        nxt.bytes_pending    = 2'd1;
                        nxt.code_accumulator = {16'd0, data_byte[4:0]};
                        nxt.sequence_class   = SEQ_TWO;
                        nxt.sequence_start   = pos;
                    end
                    else if (data_byte >= 8'd224 && data_byte <= 8'd239)
                    begin
                        nxt.bytes_pending    = 2'd2;
                        nxt.code_accumulator = {17'd0, data_byte[3:0]};
                        nxt.sequence_class   = SEQ_THREE;
                        nxt.sequence_start   = pos;
                    end
                    else if (data_byte >= 8'd240 && data_byte <= 8'd244)
                    begin
                        nxt.bytes_pending    = 2'd3;
                        nxt.code_accumulator = {18'd0, data_byte[2:0]};
                        nxt.sequence_class   = SEQ_FOUR;
                        nxt.sequence_start   = pos;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                else if (data_byte[7:6] != 2'b10)
                begin
                    err = 1'b1;
                end
                else
                begin
                    nxt.code_accumulator = acc_shift;
                    nxt.bytes_pending    = cur.bytes_pending - 2'd1;
                    if (cur.bytes_pending == 2'd1)
                    begin
                        // Overlong forms, surrogates and out-of-range values end here.
                        if (acc_shift < cp_min || acc_shift > CP_MAX ||
                            (acc_shift >= SURR_LO && acc_shift <= SURR_HI))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            fin       = 1'b1;
                            fin_cp    = acc_shift;
                            fin_start = cur.sequence_start;
                        end
                    end
                end
            end
            if (fin && !is_space(fin_cp))
            begin
                if (!cur.seen_nonspace)
                begin
                    nxt.first_position = fin_start;
                    nxt.seen_nonspace  = 1'b1;
                end
                nxt.last_end = pos_inc;
            end
            nxt.error_seen = err;
            if (is_last)
            begin
                emit          = 1'b1;
                ok            = !err && nxt.bytes_pending == 2'd0;
                res.valid_res = ok;
                if (ok && nxt.seen_nonspace)
                begin
                    res.trim_start  = nxt.first_position;
                    res.trim_length = nxt.last_end - nxt.first_position;
                end
                nxt = '0;
            end
        end
    end

endmodule

### sv/u8vtb_out_reg.sv
// Result register that holds one finished item until the consumer takes it.
module u8vtb_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  u8vtb_pkg::result_t res,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               out_free,
    output logic               valid_res,
    output logic [15:0]        trim_start,
    output logic [15:0]        trim_length
);
    import u8vtb_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign valid_res   = res_reg.valid_res;
    assign trim_start  = res_reg.trim_start;
    assign trim_length = res_reg.trim_length;

endmodule

### sv/utf8_validate_trim_bounds_unit.sv
// Top level of the streaming strict UTF-8 validator with whitespace trim bounds.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | data_byte[7:0], is_last, is_empty
//   out     | out_valid, out_stall | valid_res, trim_start[15:0], trim_length[15:0]
//
// One byte item is taken per cycle while in_stall is low. An item is held in the input
// register, where its decode updates the scan state and, on a last or empty item, loads the
// result register, from which the result is presented.
// Reset clears the scan state and both valid flags; no clearing pass is needed.
// Only an item that ends a string waits on a full, stalled result register;
// in_stall is raised then and other items keep flowing.
`include "utf8_validate_trim_bounds_unit_assert.svh"

module utf8_validate_trim_bounds_unit #(
    parameter longint unsigned MAX_LENGTH = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        is_empty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [15:0] trim_start,
    output logic [15:0] trim_length
);
    import u8vtb_pkg::*;

    // Offsets are 16 bits, so a limit above 65536 never binds before the offset cap.
    localparam logic [16:0] LEN_CAP =
        (MAX_LENGTH > 64'd65536) ? 17'h10000 : 17'(MAX_LENGTH);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_empty_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        emit;
    result_t     step_res;
    logic        out_free;
    logic        s1_advance;
    logic        in_accept;

    u8vtb_step #(
        .LEN_CAP(LEN_CAP)
    ) u_step (
        .cur       (state_reg),
        .data_byte (s1_byte_reg),
        .is_last   (s1_last_reg),
        .is_empty  (s1_empty_reg),
        .nxt       (state_next),
        .emit      (emit),
        .res       (step_res)
    );

    u8vtb_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_advance && emit),
        .res         (step_res),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_free    (out_free),
        .valid_res   (valid_res),
        .trim_start  (trim_start),
        .trim_length (trim_length)
    );

    assign s1_advance    = s1_valid_reg && (!emit || out_free);
    assign in_stall      = s1_valid_reg && emit && !out_free;
    assign in_accept     = in_valid && !in_stall;
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= data_byte;
            s1_last_reg  <= is_last;
            s1_empty_reg <= is_empty;
        end
    end

    `U8VTB_ASSERT_IMPLIES(a_stall_only_when_out_blocked, in_stall, out_valid && out_stall)
    `U8VTB_ASSERT_NEXT(a_state_clear_after_result, s1_advance && emit, state_reg == '0)
    `U8VTB_ASSERT_IMPLIES(a_invalid_has_no_bounds, out_valid && !valid_res, {trim_start, trim_length} == '0)
    `U8VTB_ASSERT_IMPLIES(a_pending_has_class, state_reg.bytes_pending != 2'd0, state_reg.sequence_class != SEQ_NONE)

endmodule
